FILE: rtl/core/bdch_pkg.sv
// ----------------------------------------------------------------------------
// bdch_pkg
// Shared types, constants and helpers of the button debounce / click / hold
// detector.
// ----------------------------------------------------------------------------
package bdch_pkg;

    // width of the free-running millisecond count
    localparam int TIME_BITS   = 32;
    // width of every configuration register
    localparam int CFG_W       = 16;
    localparam int NUM_BUTTONS = 3;
    // the button watched for a floating input
    localparam int DOWN_IDX    = 2;

    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [CFG_W-1:0]     cfg_val_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_DEBOUNCE    = 2'd0,
        REG_HOLD        = 2'd1,
        REG_DOUBLE      = 2'd2,
        REG_FLOAT_LIMIT = 2'd3
    } reg_idx_t;

    // reset values of the configuration registers
    localparam cfg_val_t DEBOUNCE_RST    = 16'd50;
    localparam cfg_val_t HOLD_RST        = 16'd1000;
    localparam cfg_val_t DOUBLE_RST      = 16'd300;
    localparam cfg_val_t FLOAT_LIMIT_RST = 16'd1000;

    // button event codes
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_PRESS   = 3'd1,
        EV_DOUBLE  = 3'd2,
        EV_RELEASE = 3'd3,
        EV_HOLD    = 3'd4
    } ev_t;

    // timing settings seen by each lane
    typedef struct packed {
        cfg_val_t debounce;
        cfg_val_t hold;
        cfg_val_t dbl;
    } lane_cfg_t;

    // what one lane reports per tick
    typedef struct packed {
        ev_t  ev;
        logic pressed;
        logic held;
    } lane_res_t;

    // wrapping time difference
    function automatic time_t elapsed(time_t now, time_t since);
        return now - since;
    endfunction

    // register value widened to the time count
    function automatic time_t widen(cfg_val_t v);
        return time_t'(v);
    endfunction

endpackage

FILE: rtl/core/bdch_lane.sv
// ----------------------------------------------------------------------------
// bdch_lane
// Per-button core: debounce, press/release tracking, double click and hold
// detection, and event selection with consumption on poll.
// ----------------------------------------------------------------------------
module bdch_lane (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic                is_low,
    input  logic                track_en,
    input  logic                poll,
    input  bdch_pkg::time_t     now,
    input  bdch_pkg::lane_cfg_t cfg,
    output bdch_pkg::lane_res_t res
);

    logic            pressed_now_reg,    pressed_now_next;
    logic            pressed_before_reg, pressed_before_next;
    bdch_pkg::time_t press_stamp_reg,    press_stamp_next;
    bdch_pkg::time_t release_stamp_reg,  release_stamp_next;
    bdch_pkg::time_t prior_stamp_reg,    prior_stamp_next;
    logic            held_reg,           held_next;
    logic            double_reg,         double_next;
    logic            hold_rep_reg,       hold_rep_next;

    logic            change;
    logic            pb_trk;
    logic            dbl_trk;
    bdch_pkg::ev_t   ev;

    // level tracking for this tick
    always_comb begin
        change = track_en && (is_low != pressed_now_reg) &&
                 (bdch_pkg::elapsed(now, release_stamp_reg) >
                  bdch_pkg::widen(cfg.debounce));
        pressed_now_next   = change ? is_low : pressed_now_reg;
        pb_trk             = change ? pressed_now_reg : pressed_before_reg;
        press_stamp_next   = (change && is_low) ? now : press_stamp_reg;
        prior_stamp_next   = (change && is_low) ? now : prior_stamp_reg;
        release_stamp_next = (change && !is_low) ? now : release_stamp_reg;
        dbl_trk = double_reg ||
                  (change && is_low &&
                   (bdch_pkg::elapsed(now, prior_stamp_reg) <
                    bdch_pkg::widen(cfg.dbl)));
        // any level change clears the hold flag; a fresh press restarts the hold timer
        if (change) begin
            held_next = 1'b0;
        end else begin
            held_next = held_reg ||
                        (track_en && pressed_now_reg &&
                         (bdch_pkg::elapsed(now, press_stamp_reg) >
                          bdch_pkg::widen(cfg.hold)));
        end
    end

    // event choice and consumption
    always_comb begin
        ev                  = bdch_pkg::EV_NONE;
        pressed_before_next = pb_trk;
        double_next         = dbl_trk;
        hold_rep_next       = hold_rep_reg;
        if (poll) begin
            if (pressed_now_next && !pb_trk) begin
                ev                  = dbl_trk ? bdch_pkg::EV_DOUBLE : bdch_pkg::EV_PRESS;
                double_next         = 1'b0;
                hold_rep_next       = 1'b0;
                pressed_before_next = pressed_now_next;
            end else if (!pressed_now_next && pb_trk) begin
                ev                  = bdch_pkg::EV_RELEASE;
                hold_rep_next       = 1'b0;
                pressed_before_next = pressed_now_next;
            end else if (held_next && !hold_rep_reg) begin
                ev            = bdch_pkg::EV_HOLD;
                hold_rep_next = 1'b1;
            end
        end
    end

    assign res.ev      = ev;
    assign res.pressed = pressed_now_next;
    assign res.held    = held_next;

    // state update on each accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_now_reg    <= 1'b0;
            pressed_before_reg <= 1'b0;
            press_stamp_reg    <= '0;
            release_stamp_reg  <= '0;
            prior_stamp_reg    <= '0;
            held_reg           <= 1'b0;
            double_reg         <= 1'b0;
            hold_rep_reg       <= 1'b0;
        end else if (accept) begin
            pressed_now_reg    <= pressed_now_next;
            pressed_before_reg <= pressed_before_next;
            press_stamp_reg    <= press_stamp_next;
            release_stamp_reg  <= release_stamp_next;
            prior_stamp_reg    <= prior_stamp_next;
            held_reg           <= held_next;
            double_reg         <= double_next;
            hold_rep_reg       <= hold_rep_next;
        end
    end

endmodule

FILE: rtl/core/bdch_float.sv
// ----------------------------------------------------------------------------
// bdch_float
// Floating input detection on the third button: disables it until reset once
// its raw level stays low beyond the limit.
// ----------------------------------------------------------------------------
module bdch_float (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic               is_low,
    input  bdch_pkg::time_t    now,
    input  bdch_pkg::cfg_val_t limit,
    output logic               down_off
);

    logic            tracking_reg,  tracking_next;
    bdch_pkg::time_t low_since_reg, low_since_next;
    logic            off_reg,       off_next;

    // low-time tracking for this tick
    always_comb begin
        tracking_next  = tracking_reg;
        low_since_next = low_since_reg;
        off_next       = off_reg;
        if (is_low) begin
            if (!tracking_reg) begin
                tracking_next  = 1'b1;
                low_since_next = now;
            end else if (bdch_pkg::elapsed(now, low_since_reg) >
                         bdch_pkg::widen(limit)) begin
                off_next = 1'b1;
            end
        end else begin
            tracking_next = 1'b0;
        end
    end

    // lanes see this tick's decision
    assign down_off = off_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tracking_reg  <= 1'b0;
            low_since_reg <= '0;
            off_reg       <= 1'b0;
        end else if (accept) begin
            tracking_reg  <= tracking_next;
            low_since_reg <= low_since_next;
            off_reg       <= off_next;
        end
    end

endmodule

FILE: rtl/core/bdch_merge.sv
// ----------------------------------------------------------------------------
// bdch_merge
// Merges the lane results into one result transaction and buffers it in an
// output register with a skid stage.
// ----------------------------------------------------------------------------
module bdch_merge (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         push,
    input  bdch_pkg::lane_res_t [bdch_pkg::NUM_BUTTONS-1:0] lanes,
    input  logic                                         down_off,
    output logic                                         space,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    output logic [bdch_pkg::M_DATA_W-1:0]                m_tdata
);

    logic [bdch_pkg::M_DATA_W-1:0] item;
    logic [bdch_pkg::NUM_BUTTONS-1:0] pmask;
    logic [bdch_pkg::NUM_BUTTONS-1:0] hmask;

    logic                          out_valid_reg;
    logic [bdch_pkg::M_DATA_W-1:0] out_data_reg;
    logic                          skid_valid_reg;
    logic [bdch_pkg::M_DATA_W-1:0] skid_data_reg;

    // gather masks from the lanes
    always_comb begin
        for (int i = 0; i < bdch_pkg::NUM_BUTTONS; i++) begin
            pmask[i] = lanes[i].pressed;
            hmask[i] = lanes[i].held;
        end
    end

    // pack the result fields
    assign item = {down_off, hmask, pmask, lanes[2].ev, lanes[1].ev, lanes[0].ev};

    assign space    = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // output register and skid stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            if (out_valid_reg && !m_tready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (out_valid_reg && m_tready) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload moves
    always_ff @(posedge aclk) begin
        if (push) begin
            if (out_valid_reg && !m_tready) begin
                skid_data_reg <= item;
            end else begin
                out_data_reg <= item;
            end
        end else if (out_valid_reg && m_tready && skid_valid_reg) begin
            out_data_reg <= skid_data_reg;
        end
    end

endmodule

FILE: rtl/core/button_debounce_click_hold_detector.sv
// ----------------------------------------------------------------------------
// button_debounce_click_hold_detector
// Output: each result is registered, into the skid stage when the output stalls.
// Throughput: one tick per cycle while the skid stage is empty; the three
// button lanes and the floating detector update all their state on accept.
// Reset: synchronous, active low; clears the time count and all button state
// and loads the default debounce, hold, double-click and floating limits.
// ----------------------------------------------------------------------------
module button_debounce_click_hold_detector (
    input  logic                               aclk,
    input  logic                               aresetn,
    // tick input: level_menu, level_up, level_down, poll, zero fill
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bdch_pkg::S_DATA_W-1:0]      s_tdata,
    // result: event_menu[2:0], event_up[2:0], event_down[2:0],
    // pressed_mask[2:0], holding_mask[2:0], down_disabled
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bdch_pkg::M_DATA_W-1:0]      m_tdata,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [bdch_pkg::CFG_W-1:0]         cfg_wdata
);

    bdch_pkg::cfg_val_t debounce_reg;
    bdch_pkg::cfg_val_t hold_reg;
    bdch_pkg::cfg_val_t double_reg;
    bdch_pkg::cfg_val_t float_limit_reg;
    bdch_pkg::time_t    now_reg;

    logic                                            accept;
    logic                                            space;
    logic                                            poll;
    logic                                            down_off;
    logic [bdch_pkg::NUM_BUTTONS-1:0]                low;
    logic [bdch_pkg::NUM_BUTTONS-1:0]                track_en;
    bdch_pkg::lane_cfg_t                             lane_cfg;
    bdch_pkg::lane_res_t [bdch_pkg::NUM_BUTTONS-1:0] lane_res;

    assign s_tready = space;
    assign accept   = s_tvalid && space;
    assign poll     = s_tdata[3];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg    <= bdch_pkg::DEBOUNCE_RST;
            hold_reg        <= bdch_pkg::HOLD_RST;
            double_reg      <= bdch_pkg::DOUBLE_RST;
            float_limit_reg <= bdch_pkg::FLOAT_LIMIT_RST;
        end else if (cfg_we) begin
            case (bdch_pkg::reg_idx_t'(cfg_index))
                bdch_pkg::REG_DEBOUNCE:    debounce_reg    <= cfg_wdata;
                bdch_pkg::REG_HOLD:        hold_reg        <= cfg_wdata;
                bdch_pkg::REG_DOUBLE:      double_reg      <= cfg_wdata;
                bdch_pkg::REG_FLOAT_LIMIT: float_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // free-running millisecond count, one step per tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg <= '0;
        end else if (accept) begin
            now_reg <= now_reg + bdch_pkg::time_t'(1);
        end
    end

    assign lane_cfg.debounce = debounce_reg;
    assign lane_cfg.hold     = hold_reg;
    assign lane_cfg.dbl      = double_reg;

    // floating detection on the third button
    bdch_float u_float (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .is_low   (low[bdch_pkg::DOWN_IDX]),
        .now      (now_reg),
        .limit    (float_limit_reg),
        .down_off (down_off)
    );

    // one lane per button
    for (genvar i = 0; i < bdch_pkg::NUM_BUTTONS; i++) begin : g_lane
        assign low[i]      = !s_tdata[i];
        assign track_en[i] = (i == bdch_pkg::DOWN_IDX) ? !down_off : 1'b1;

        bdch_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .accept   (accept),
            .is_low   (low[i]),
            .track_en (track_en[i]),
            .poll     (poll),
            .now      (now_reg),
            .cfg      (lane_cfg),
            .res      (lane_res[i])
        );
    end

    // merge lanes and buffer the result
    bdch_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept),
        .lanes    (lane_res),
        .down_off (down_off),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
